FILE: design/bfs_pkg.sv
// Shared types and constants for the byte frame synchronizer.
// No dependencies; imported by the core and by the port checker.
`default_nettype none

package bfs_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_HEADER  = 1'b0,
    REG_TRAILER = 1'b1
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'hF0;

  // Result tdata layout: frame_byte in the low byte, frame_count above it
  localparam int unsigned OUT_DATA_W = BYTE_W + COUNT_W;

endpackage

`default_nettype wire

FILE: design/byte_frame_synchronizer_core.sv
// Byte frame synchronizer: top level, hunts for header/trailer framed blocks.
// Depends on bfs_pkg; checked by bfs_checker (bound in its own file).
`default_nettype none

// Byte frame synchronizer. Raw bytes enter on the in_ stream one transfer per
// clock. Each byte goes down a delay line of TRAILER_OFFSET stages, so when a
// byte leaves the line the byte TRAILER_OFFSET positions after it is the one
// arriving. A leaving byte that equals header_marker while the arriving byte
// equals trailer_marker starts a frame of FRAME_BYTES bytes, all of which are
// passed out in stream order: tuser marks the first byte, tlast the last,
// and tdata[39:8] carries the running frame number (wrapping, 1 for the first
// frame after reset). While hunting, leaving bytes that do not start a frame
// are dropped; the byte right after a frame is checked as a header at once.
// Nothing comes out until TRAILER_OFFSET+1 bytes have arrived after reset.
// Rate: one byte per clock, sustained while out_tready stays high. A result
// comes from the single output register, in the cycle after its input transfer.
// A new byte is taken in the same cycle the last result leaves; while a
// result waits for out_tready, in_tready stays low and the input is held off.
// Marker writes on the cfg_ port take effect on the next header check; a
// write to an index with no register is dropped.
module byte_frame_synchronizer_core
  import bfs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES    = 104,
  parameter int unsigned TRAILER_OFFSET = 100
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_addr,
  input  wire logic [BYTE_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] frame_byte, [39:8] frame_count
  output logic                       out_tlast,  // frame_last
  output logic                       out_tuser   // [0] frame_first
);

  localparam int unsigned FILL_W = $clog2(TRAILER_OFFSET + 1);
  localparam int unsigned LEFT_W = $clog2(FRAME_BYTES);

  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(TRAILER_OFFSET);
  localparam logic [LEFT_W-1:0] LEFT_START = LEFT_W'(FRAME_BYTES - 1);
  localparam logic [LEFT_W-1:0] LEFT_ONE   = LEFT_W'(1);

  logic [BYTE_W-1:0]  header_r, trailer_r;
  logic [BYTE_W-1:0]  win_r [TRAILER_OFFSET];
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_first_r, out_last_r;

  logic               accept;
  logic               window_full;
  logic [BYTE_W-1:0]  leaving;
  logic               emit, first, last;

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = !out_valid_r || out_tready;
  assign window_full = (fill_r == FILL_FULL);
  assign leaving     = win_r[TRAILER_OFFSET-1];

  // Marker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RESET;
      trailer_r <= TRAILER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HEADER:  header_r  <= cfg_wdata;
        REG_TRAILER: trailer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Delay line: newest byte at stage 0. Contents are only read once full,
  // so no reset is needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_tdata;
      for (int unsigned i = 1; i < TRAILER_OFFSET; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Frame tracking: in a frame, pass the leaving byte; otherwise check it
  // against the header with the arriving byte as trailer candidate.
  always_comb begin
    fill_nxt  = fill_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    emit      = 1'b0;
    first     = 1'b0;
    last      = 1'b0;
    if (!window_full) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (left_r != '0) begin
      emit     = 1'b1;
      last     = (left_r == LEFT_ONE);
      left_nxt = left_r - LEFT_ONE;
    end else if (leaving == header_r && in_tdata == trailer_r) begin
      emit      = 1'b1;
      first     = 1'b1;
      last      = (LEFT_START == '0);
      left_nxt  = LEFT_START;
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      left_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      fill_r  <= fill_nxt;
      left_r  <= left_nxt;
      count_r <= count_nxt;
    end
  end

  // Output register: valid loads on every accepted byte, the payload only on emitted ones; drop valid once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r  <= leaving;
      out_count_r <= count_nxt;
      out_first_r <= first;
      out_last_r  <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_first_r;

endmodule

`default_nettype wire

FILE: design/bfs_checker.sv
// Port-level checks for the byte frame synchronizer core.
// Depends on bfs_pkg; bound to byte_frame_synchronizer_core below.
`default_nettype none

module bfs_checker
  import bfs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast,
  input wire logic                  out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Input is held off while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // A frame never starts and ends on the same byte
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tlast && out_tuser))
    else $error("first and last on one byte");

endmodule

bind byte_frame_synchronizer_core bfs_checker u_bfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
